// File: sv/krt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// krt_pkg
// Types and constants shared by the keyed record table core and its store.
// ----------------------------------------------------------------------------
package krt_pkg;

  localparam int DEF_CAPACITY = 32;
  localparam int FILL_W       = 6;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MOVE_RD,
    ST_MOVE_WR,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [31:0] key;
    logic [23:0] price;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } record_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] key;
    logic [23:0] price_in;
    logic [4:0]  day_in;
    logic [3:0]  month_in;
    logic [13:0] year_in;
  } in_word_t;

  typedef struct packed {
    logic              hit;
    logic [31:0]       key_out;
    logic [23:0]       price_out;
    logic [4:0]        day_out;
    logic [3:0]        month_out;
    logic [13:0]       year_out;
    logic [FILL_W-1:0] fill;
  } out_word_t;

endpackage
`default_nettype wire

// File: sv/krt_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// krt_store
// Record memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module krt_store #(
  parameter int DEPTH  = krt_pkg::DEF_CAPACITY,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire                    clk,
  input  wire                    wr_en,
  input  wire  [ADDR_W-1:0]      wr_addr,
  input  wire  krt_pkg::record_t wr_data,
  input  wire  [ADDR_W-1:0]      rd_addr,
  output krt_pkg::record_t       rd_data
);
  import krt_pkg::*;

  record_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// File: sv/keyed_record_table_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_record_table_core
// Unsorted record table with append insert, linear lookup and swap delete.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall / in_data carries one command word
//   (insert, lookup, delete, or the unused code which does nothing).
//   Output channel out_valid / out_stall / out_data gives exactly one result
//   word per command: hit flag, found record on a lookup hit, and the fill.
//   One command is in flight at a time; in_stall is low only when idle.
//   Insert, the unused code and any command on an empty table go from
//   acceptance through the result register to the output register. Lookup
//   and delete walk the slots through one memory read port and one key
//   comparator, one slot per cycle, pipelined against the registered read;
//   a delete that moves the last record into the hole adds an extra read and
//   write. The next command is taken the cycle after a result is loaded.
//   The output register frees the core: the next command is taken while a
//   result still waits under out_stall, and only the next result waits.
//   Reset empties the table (count to zero); record contents are not
//   cleared and are never read before being written.
// ----------------------------------------------------------------------------
module keyed_record_table_core #(
  parameter int CAPACITY = krt_pkg::DEF_CAPACITY
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  wire  krt_pkg::in_word_t  in_data,
  output logic                     out_valid,
  input  wire                      out_stall,
  output krt_pkg::out_word_t       out_data
);
  import krt_pkg::*;

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [ADDR_W-1:0] cmp_r, cmp_nxt;
  logic              pend_r, pend_nxt;
  logic              del_r, del_nxt;
  logic [31:0]       key_r, key_nxt;
  out_word_t         res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_r, out_nxt;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  record_t           mem_wd;
  logic [ADDR_W-1:0] mem_ra;
  record_t           rd_data;

  logic              accept;
  logic              full;
  logic              empty;
  logic              match;
  logic              at_last;
  logic              load;
  logic [CNT_W-1:0]  count_dec;
  logic [CNT_W-1:0]  count_inc;
  logic [ADDR_W-1:0] last_idx;
  logic [FILL_W-1:0] fill_now, fill_dec, fill_inc;

  function automatic logic [FILL_W-1:0] to_fill(input logic [CNT_W-1:0] c);
    logic [CNT_W+FILL_W-1:0] wide;
    wide = {{FILL_W{1'b0}}, c};
    return wide[FILL_W-1:0];
  endfunction

  krt_store #(
    .DEPTH  (CAPACITY),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_wa),
    .wr_data (mem_wd),
    .rd_addr (mem_ra),
    .rd_data (rd_data)
  );

  assign accept    = (state_r == ST_IDLE) && in_valid;
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign empty     = (count_r == '0);
  assign count_dec = count_r - CNT_W'(1);
  assign count_inc = count_r + CNT_W'(1);
  assign last_idx  = count_dec[ADDR_W-1:0];
  assign match     = pend_r && (rd_data.key == key_r);
  assign at_last   = (cmp_r == last_idx);
  assign load      = (state_r == ST_RESP) && (!out_valid_r || !out_stall);
  assign fill_now  = to_fill(count_r);
  assign fill_dec  = to_fill(count_dec);
  assign fill_inc  = to_fill(count_inc);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if ((in_data.cmd == CMD_LOOKUP || in_data.cmd == CMD_DELETE) && !empty) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end
      ST_SCAN: begin
        if (match) begin
          state_nxt = (del_r && !at_last) ? ST_MOVE_RD : ST_RESP;
        end else if (pend_r && at_last) begin
          state_nxt = ST_RESP;
        end
      end
      ST_MOVE_RD: state_nxt = ST_MOVE_WR;
      ST_MOVE_WR: state_nxt = ST_RESP;
      ST_RESP: begin
        if (load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    count_nxt = count_r;
    idx_nxt   = idx_r;
    cmp_nxt   = cmp_r;
    pend_nxt  = pend_r;
    del_nxt   = del_r;
    key_nxt   = key_r;
    res_nxt   = res_r;
    mem_we    = 1'b0;
    mem_wa    = count_r[ADDR_W-1:0];
    mem_wd    = '{key: in_data.key, price: in_data.price_in, day: in_data.day_in,
                  month: in_data.month_in, year: in_data.year_in};
    mem_ra    = idx_r;
    out_nxt   = out_r;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          key_nxt      = in_data.key;
          del_nxt      = (in_data.cmd == CMD_DELETE);
          idx_nxt      = '0;
          pend_nxt     = 1'b0;
          res_nxt      = '0;
          res_nxt.fill = fill_now;
          if (in_data.cmd == CMD_INSERT && !full) begin
            mem_we       = 1'b1;
            count_nxt    = count_inc;
            res_nxt.hit  = 1'b1;
            res_nxt.fill = fill_inc;
          end
        end
      end
      ST_SCAN: begin
        // read slot idx while comparing the word read last cycle
        mem_ra   = idx_r;
        idx_nxt  = idx_r + ADDR_W'(1);
        cmp_nxt  = idx_r;
        pend_nxt = 1'b1;
        if (match) begin
          cmp_nxt     = cmp_r;
          res_nxt.hit = 1'b1;
          if (!del_r) begin
            res_nxt.key_out   = rd_data.key;
            res_nxt.price_out = rd_data.price;
            res_nxt.day_out   = rd_data.day;
            res_nxt.month_out = rd_data.month;
            res_nxt.year_out  = rd_data.year;
          end else if (at_last) begin
            count_nxt    = count_dec;
            res_nxt.fill = fill_dec;
          end
        end
      end
      ST_MOVE_RD: begin
        mem_ra = last_idx;
      end
      ST_MOVE_WR: begin
        // last record fills the hole
        mem_we       = 1'b1;
        mem_wa       = cmp_r;
        mem_wd       = rd_data;
        count_nxt    = count_dec;
        res_nxt.fill = fill_dec;
      end
      ST_RESP: begin
        if (load) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    cmp_r <= cmp_nxt;
    del_r <= del_nxt;
    key_r <= key_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("record count beyond capacity");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != ST_IDLE))
    else $error("core idle straight after taking a command");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !empty)
    else $error("scan running on an empty table");

  a_move_needs_two: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MOVE_WR) |-> (count_r >= CNT_W'(2)) && (cmp_r != last_idx))
    else $error("swap delete on the last slot");
`endif

endmodule
`default_nettype wire

// File: bench/tb_keyed_record_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyed_record_table_core
// Self-checking bench for the keyed record table core. Directed corner words,
// a fill past capacity and back to empty, a long output hold-off, a
// back-to-back burst and weighted random traffic. A local copy of the table
// predicts every result word, which is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_keyed_record_table_core;
  import krt_pkg::*;

  localparam int CAP            = DEF_CAPACITY;
  localparam int SETTLE_CYCLES  = CAP + 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 250;
  localparam int MAX_REPORTS    = 10;
  localparam int POOL_SIZE      = 40;
  localparam int RANDOM_WORDS   = 1200;
  localparam int BLOCK_WORDS    = 50;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  // local copy of the table
  record_t     rec_store [CAP];
  int unsigned rec_count;

  out_word_t   expected_results [$];
  logic [31:0] key_pool [POOL_SIZE];

  int unsigned fail_count   = 0;
  int unsigned idle_cycles  = 0;
  int unsigned result_index = 0;
  bit          quiet_mode   = 1'b0;
  int unsigned rx_hold_req  = 0;

  keyed_record_table_core #(
    .CAPACITY(CAP)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned draw_wait();
    if (quiet_mode) return 0;
    return $urandom_range(15, 0);
  endfunction

  // Applies one command to the local table and returns the result word.
  function automatic out_word_t predict_table_op(in_word_t w);
    out_word_t   res;
    int unsigned slot;
    res = '0;
    case (cmd_t'(w.cmd))
      CMD_INSERT: begin
        if (rec_count < CAP) begin
          rec_store[rec_count].key   = w.key;
          rec_store[rec_count].price = w.price_in;
          rec_store[rec_count].day   = w.day_in;
          rec_store[rec_count].month = w.month_in;
          rec_store[rec_count].year  = w.year_in;
          rec_count++;
          res.hit = 1'b1;
        end
      end
      CMD_LOOKUP, CMD_DELETE: begin
        slot = 0;
        while (slot < rec_count && rec_store[slot].key != w.key) slot++;
        if (slot < rec_count) begin
          res.hit = 1'b1;
          if (cmd_t'(w.cmd) == CMD_LOOKUP) begin
            res.key_out   = rec_store[slot].key;
            res.price_out = rec_store[slot].price;
            res.day_out   = rec_store[slot].day;
            res.month_out = rec_store[slot].month;
            res.year_out  = rec_store[slot].year;
          end else begin
            // swap delete: last record fills the hole
            rec_store[slot] = rec_store[rec_count - 1];
            rec_count--;
          end
        end
      end
      default: ;
    endcase
    res.fill = rec_count[FILL_W-1:0];
    return res;
  endfunction

  function automatic in_word_t make_word(cmd_t c, logic [31:0] k);
    in_word_t w;
    w.cmd      = c;
    w.key      = k;
    w.price_in = 24'($urandom_range(24'hFF_FFFF, 0));
    w.day_in   = 5'($urandom_range(31, 0));
    w.month_in = 4'($urandom_range(12, 0));
    w.year_in  = 14'($urandom_range(9999, 0));
    return w;
  endfunction

  // mostly keys from a small pool, so lookups hit and duplicates build up
  function automatic logic [31:0] pick_key();
    if ($urandom_range(99, 0) < 85) return key_pool[$urandom_range(POOL_SIZE - 1, 0)];
    return $urandom;
  endfunction

  function automatic cmd_t pick_cmd(int unsigned insert_pct);
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 3) return CMD_NONE;
    if (r < 3 + insert_pct) return CMD_INSERT;
    return $urandom_range(1, 0) ? CMD_LOOKUP : CMD_DELETE;
  endfunction

  // Offers one word after a random gap; returns at the accepting edge.
  task automatic send_word(input in_word_t w);
    int unsigned gap;
    gap = draw_wait();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(predict_table_op(w));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic test_directed();
    in_word_t w;
    send_word(make_word(CMD_LOOKUP, 32'h0));
    send_word(make_word(CMD_DELETE, 32'hFFFF_FFFF));
    send_word(make_word(CMD_NONE, 32'h1234_5678));
    w     = '0;
    w.cmd = CMD_INSERT;
    send_word(w);
    w.key      = '1;
    w.price_in = '1;
    w.day_in   = 5'd31;
    w.month_in = 4'd12;
    w.year_in  = 14'd9999;
    send_word(w);
    // second record under key zero, different contents
    send_word(make_word(CMD_INSERT, 32'h0));
    send_word(make_word(CMD_INSERT, 32'hA5A5_5A5A));
    send_word(make_word(CMD_LOOKUP, 32'hFFFF_FFFF));
    send_word(make_word(CMD_LOOKUP, 32'h0));
    send_word(make_word(CMD_LOOKUP, 32'h0000_0001));
    send_word(make_word(CMD_DELETE, 32'h0));
    send_word(make_word(CMD_LOOKUP, 32'h0));
    send_word(make_word(CMD_DELETE, 32'hA5A5_5A5A));
    // deleting the record in the last slot
    send_word(make_word(CMD_DELETE, 32'hFFFF_FFFF));
    send_word(make_word(CMD_DELETE, 32'hFFFF_FFFF));
    send_word(make_word(CMD_NONE, 32'h0));
    send_word(make_word(CMD_LOOKUP, 32'h0));
  endtask

  task automatic test_fill_and_empty();
    int unsigned n;
    wait_idle();
    for (n = 0; n < CAP + 3; n++) send_word(make_word(CMD_INSERT, 32'hC000_0000 + n));
    send_word(make_word(CMD_LOOKUP, 32'hC000_0000 + CAP - 2));
    send_word(make_word(CMD_LOOKUP, 32'hC000_0000 + CAP + 1));
    for (n = 1; n < CAP + 3; n += 2) send_word(make_word(CMD_DELETE, 32'hC000_0000 + n));
    for (n = 0; n < CAP + 3; n += 2) send_word(make_word(CMD_DELETE, 32'hC000_0000 + n));
    send_word(make_word(CMD_DELETE, 32'h0));
    send_word(make_word(CMD_LOOKUP, 32'h0));
  endtask

  // Sink sits on one result while the source keeps offering words.
  task automatic test_output_hold();
    int unsigned n;
    wait_idle();
    quiet_mode  = 1'b1;
    rx_hold_req = HOLD_CYCLES;
    for (n = 0; n < 20; n++) send_word(make_word(pick_cmd(50), pick_key()));
    quiet_mode = 1'b0;
  endtask

  task automatic test_back_to_back();
    int unsigned n;
    wait_idle();
    quiet_mode = 1'b1;
    for (n = 0; n < 150; n++) send_word(make_word(pick_cmd(35), pick_key()));
    quiet_mode = 1'b0;
  endtask

  task automatic test_random_traffic();
    int unsigned n;
    int unsigned mode;
    int unsigned insert_pct;
    insert_pct = 40;
    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (n % BLOCK_WORDS == 0) begin
        if (n % (4 * BLOCK_WORDS) == 0) wait_idle();
        // fill-heavy, drain-heavy, balanced, and now and then a gapless block
        mode       = $urandom_range(3, 0);
        insert_pct = (mode == 0) ? 70 : (mode == 1) ? 20 : 40;
        quiet_mode = (mode == 3);
      end
      send_word(make_word(pick_cmd(insert_pct), pick_key()));
    end
    quiet_mode = 1'b0;
  endtask

  initial begin : result_sink
    int unsigned hold;
    wait (rst_n === 1'b1);
    forever begin
      if (rx_hold_req != 0) begin
        hold        = rx_hold_req;
        rx_hold_req = 0;
      end else begin
        hold = draw_wait();
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin : check_results
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("result %0d: unexpected word %h", result_index, out_data);
      end else begin
        want = expected_results.pop_front();
        if (out_data.hit !== want.hit || out_data.key_out !== want.key_out ||
            out_data.price_out !== want.price_out || out_data.day_out !== want.day_out ||
            out_data.month_out !== want.month_out || out_data.year_out !== want.year_out ||
            out_data.fill !== want.fill) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("result %0d mismatch: exp hit=%0d key=%h price=%0d date=%0d/%0d/%0d fill=%0d",
                     result_index, want.hit, want.key_out, want.price_out, want.day_out,
                     want.month_out, want.year_out, want.fill);
            $display("                     got hit=%0d key=%h price=%0d date=%0d/%0d/%0d fill=%0d",
                     out_data.hit, out_data.key_out, out_data.price_out, out_data.day_out,
                     out_data.month_out, out_data.year_out, out_data.fill);
          end
        end
      end
      result_index++;
    end
  end

  // no word moving on either side for too long means a hang
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned n;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7FFF_FFFF;
    for (n = 4; n < POOL_SIZE; n++) key_pool[n] = $urandom;
    rec_count = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_fill_and_empty();
    test_output_hold();
    test_back_to_back();
    test_random_traffic();
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
